// ----- rtl/core/gga_pkg.sv -----
// Shared types, character codes and text tables for the GGA position filter.
`default_nettype none

package gga_pkg;

    localparam int LEN_W = 4;   // field length counters and emit index (stores are at most 15)

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] FIX_GPS    = 8'h31;
    localparam logic [7:0] FIX_DGPS   = 8'h32;

    localparam logic [2:0] TOK_LAT = 3'd3;
    localparam logic [2:0] TOK_NS  = 3'd4;
    localparam logic [2:0] TOK_LON = 3'd5;
    localparam logic [2:0] TOK_EW  = 3'd6;
    localparam logic [2:0] TOK_FIX = 3'd7;

    localparam logic [1:0] SLOT_LAT = 2'd0;
    localparam logic [1:0] SLOT_NS  = 2'd1;
    localparam logic [1:0] SLOT_LON = 2'd2;
    localparam logic [1:0] SLOT_EW  = 2'd3;

    localparam logic [LEN_W-1:0] LAT_LABEL_LEN = LEN_W'(5);
    localparam logic [LEN_W-1:0] LON_LABEL_LEN = LEN_W'(8);

    // start request handed from the parser to the emitter on a printing newline
    typedef struct packed {
        logic                  start;
        logic                  trunc;
        logic [3:0][LEN_W-1:0] len;     // indexed by SLOT_*
    } emit_req_t;

    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;   // $
            3'd1:    c = 8'h47;   // G
            3'd2:    c = 8'h4E;   // N
            3'd3:    c = 8'h47;   // G
            3'd4:    c = 8'h47;   // G
            3'd5:    c = 8'h41;   // A
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] lat_label_char(input logic [LEN_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h4C;   // L
            4'd1:    c = 8'h61;   // a
            4'd2:    c = 8'h74;   // t
            4'd3:    c = 8'h3A;   // :
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] lon_label_char(input logic [LEN_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd1:    c = 8'h7C;   // |
            4'd3:    c = 8'h4C;   // L
            4'd4:    c = 8'h6F;   // o
            4'd5:    c = 8'h6E;   // n
            4'd6:    c = 8'h3A;   // :
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gga_mem.sv -----
// Field character store: one write port, one registered read port.
`default_nettype none

module gga_mem #(
    parameter int DEPTH = 28,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gga_parse.sv -----
// Line parser: prefix check, token split, field capture into the store.
`default_nettype none

module gga_parse
    import gga_pkg::*;
#(
    parameter int LINE_CAP  = 100,
    parameter int COORD_MAX = 12,
    parameter int HEMI_MAX  = 2,
    parameter int POS_W     = 7,
    parameter int AW        = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,      // item accepted this cycle
    input  wire logic [7:0]    rx_byte,
    output logic               wr_en,
    output logic      [AW-1:0] wr_addr,
    output logic      [7:0]    wr_data,
    output emit_req_t          req
);

    localparam int BASE_NS  = COORD_MAX;
    localparam int BASE_LON = COORD_MAX + HEMI_MAX;
    localparam int BASE_EW  = 2 * COORD_MAX + HEMI_MAX;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  prefix_reg, prefix_next;
    logic [2:0]            tc_reg, tc_next;
    logic                  in_tok_reg, in_tok_next;
    logic [3:0][LEN_W-1:0] len_reg, len_next;
    logic [7:0]            fix_reg, fix_next;
    logic                  fix_seen_reg, fix_seen_next;
    logic                  trunc_reg, trunc_next;
    logic                  ended_reg, ended_next;

    always_comb
    begin
        logic [2:0]       tc;
        logic [1:0]       slot;
        logic             hit;
        logic [LEN_W-1:0] cap;
        logic [AW-1:0]    base;

        pos_next      = pos_reg;
        prefix_next   = prefix_reg;
        tc_next       = tc_reg;
        in_tok_next   = in_tok_reg;
        len_next      = len_reg;
        fix_next      = fix_reg;
        fix_seen_next = fix_seen_reg;
        trunc_next    = trunc_reg;
        ended_next    = ended_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = rx_byte;
        req           = '0;
        tc            = tc_reg;
        slot          = SLOT_LAT;
        hit           = 1'b0;
        cap           = LEN_W'(COORD_MAX);
        base          = '0;

        if (take)
        begin
            if (rx_byte == CHAR_LF)
            begin
                req.start = prefix_reg && (pos_reg >= POS_W'(6)) && fix_seen_reg &&
                            (fix_reg == FIX_GPS || fix_reg == FIX_DGPS);
                req.trunc = trunc_reg;
                req.len   = len_reg;
                pos_next      = '0;
                prefix_next   = 1'b1;
                tc_next       = '0;
                in_tok_next   = 1'b0;
                len_next      = '0;
                fix_next      = '0;
                fix_seen_next = 1'b0;
                trunc_next    = 1'b0;
                ended_next    = 1'b0;
            end
            else if (rx_byte != CHAR_CR && pos_reg < POS_W'(LINE_CAP - 1))
            begin
                if (!ended_reg)
                begin
                    if (rx_byte == CHAR_NUL)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        if (pos_reg < POS_W'(6) && rx_byte != tag_char(pos_reg[2:0]))
                        begin
                            prefix_next = 1'b0;
                        end
                        if (rx_byte == CHAR_COMMA)
                        begin
                            in_tok_next = 1'b0;
                        end
                        else
                        begin
                            if (!in_tok_reg && tc_reg != TOK_FIX)
                            begin
                                tc = tc_reg + 3'd1;
                            end
                            in_tok_next = 1'b1;
                            tc_next     = tc;
                            if (!in_tok_reg && tc == TOK_FIX && !fix_seen_reg)
                            begin
                                fix_next      = rx_byte;
                                fix_seen_next = 1'b1;
                            end
                            case (tc)
                                TOK_LAT:
                                begin
                                    hit = 1'b1; slot = SLOT_LAT;
                                    cap = LEN_W'(COORD_MAX); base = '0;
                                end
                                TOK_NS:
                                begin
                                    hit = 1'b1; slot = SLOT_NS;
                                    cap = LEN_W'(HEMI_MAX); base = AW'(BASE_NS);
                                end
                                TOK_LON:
                                begin
                                    hit = 1'b1; slot = SLOT_LON;
                                    cap = LEN_W'(COORD_MAX); base = AW'(BASE_LON);
                                end
                                TOK_EW:
                                begin
                                    hit = 1'b1; slot = SLOT_EW;
                                    cap = LEN_W'(HEMI_MAX); base = AW'(BASE_EW);
                                end
                                default:
                                begin
                                    hit = 1'b0;
                                end
                            endcase
                            if (hit)
                            begin
                                if (len_reg[slot] < cap)
                                begin
                                    wr_en          = 1'b1;
                                    wr_addr        = base + AW'(len_reg[slot]);
                                    len_next[slot] = len_reg[slot] + LEN_W'(1);
                                end
                                else
                                begin
                                    trunc_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                // a NUL inside the tag spoils the prefix
                if ((ended_reg || rx_byte == CHAR_NUL) && pos_reg < POS_W'(6))
                begin
                    prefix_next = 1'b0;
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            prefix_reg   <= 1'b1;
            tc_reg       <= '0;
            in_tok_reg   <= 1'b0;
            len_reg      <= '0;
            fix_reg      <= '0;
            fix_seen_reg <= 1'b0;
            trunc_reg    <= 1'b0;
            ended_reg    <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            prefix_reg   <= prefix_next;
            tc_reg       <= tc_next;
            in_tok_reg   <= in_tok_next;
            len_reg      <= len_next;
            fix_reg      <= fix_next;
            fix_seen_reg <= fix_seen_next;
            trunc_reg    <= trunc_next;
            ended_reg    <= ended_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gga_emit.sv -----
// Output sequencer: walks labels and stored fields, one character per item.
`default_nettype none

module gga_emit
    import gga_pkg::*;
#(
    parameter int COORD_MAX = 12,
    parameter int HEMI_MAX  = 2,
    parameter int AW        = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  emit_req_t          req,
    output logic               idle,
    output logic               rd_en,
    output logic      [AW-1:0] rd_addr,
    input  wire logic [7:0]    rd_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic      [7:0]    out_char,
    output logic               last_char,
    output logic               clipped
);

    localparam int BASE_NS  = COORD_MAX;
    localparam int BASE_LON = COORD_MAX + HEMI_MAX;
    localparam int BASE_EW  = 2 * COORD_MAX + HEMI_MAX;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SHOW  = 3'b100
    } state_t;

    typedef enum logic [7:0] {
        SEG_LAT_LBL = 8'b0000_0001,
        SEG_LAT     = 8'b0000_0010,
        SEG_NS      = 8'b0000_0100,
        SEG_LON_LBL = 8'b0000_1000,
        SEG_LON     = 8'b0001_0000,
        SEG_EW      = 8'b0010_0000,
        SEG_CR      = 8'b0100_0000,
        SEG_LF      = 8'b1000_0000
    } seg_t;

    state_t                state_reg, state_next;
    seg_t                  seg_reg, seg_next;
    logic [LEN_W-1:0]      idx_reg, idx_next;
    logic [3:0][LEN_W-1:0] len_reg, len_next;
    logic                  trunc_reg, trunc_next;

    logic [LEN_W-1:0]      seg_len;
    seg_t                  seg_after;
    logic [AW-1:0]         seg_base;

    always_comb
    begin
        case (seg_reg)
            SEG_LAT_LBL: begin seg_len = LAT_LABEL_LEN;    seg_after = SEG_LAT;     end
            SEG_LAT:     begin seg_len = len_reg[SLOT_LAT]; seg_after = SEG_NS;      end
            SEG_NS:      begin seg_len = len_reg[SLOT_NS];  seg_after = SEG_LON_LBL; end
            SEG_LON_LBL: begin seg_len = LON_LABEL_LEN;    seg_after = SEG_LON;     end
            SEG_LON:     begin seg_len = len_reg[SLOT_LON]; seg_after = SEG_EW;      end
            SEG_EW:      begin seg_len = len_reg[SLOT_EW];  seg_after = SEG_CR;      end
            SEG_CR:      begin seg_len = LEN_W'(1);        seg_after = SEG_LF;      end
            SEG_LF:      begin seg_len = LEN_W'(1);        seg_after = SEG_LF;      end
            default:     begin seg_len = LEN_W'(1);        seg_after = SEG_LF;      end
        endcase
    end

    always_comb
    begin
        case (seg_reg)
            SEG_NS:  seg_base = AW'(BASE_NS);
            SEG_LON: seg_base = AW'(BASE_LON);
            SEG_EW:  seg_base = AW'(BASE_EW);
            default: seg_base = '0;
        endcase
    end

    assign rd_addr = seg_base + AW'(idx_reg);

    always_comb
    begin
        case (seg_reg)
            SEG_LAT_LBL: out_char = lat_label_char(idx_reg);
            SEG_LON_LBL: out_char = lon_label_char(idx_reg);
            SEG_CR:      out_char = CHAR_CR;
            SEG_LF:      out_char = CHAR_LF;
            default:     out_char = rd_data;
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SHOW);
    assign last_char = (seg_reg == SEG_LF);
    assign clipped   = trunc_reg;

    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        trunc_next = trunc_reg;
        rd_en      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    len_next   = req.len;
                    trunc_next = req.trunc;
                    seg_next   = SEG_LAT_LBL;
                    idx_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // empty fields are passed over without a character
                if (seg_len == '0)
                begin
                    seg_next = seg_after;
                    idx_next = '0;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SHOW;
                end
            end
            ST_SHOW:
            begin
                if (out_ready)
                begin
                    if (seg_reg == SEG_LF)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (idx_reg + LEN_W'(1) == seg_len)
                    begin
                        seg_next   = seg_after;
                        idx_next   = '0;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_reg   <= SEG_LAT_LBL;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        trunc_reg <= trunc_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/nmea_gga_position_filter.sv -----
// Top level of the GGA position filter: parser, field store and output sequencer.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  rx      | in  | in_valid / in_ready  | rx_byte[7:0]
//  tx      | out | out_valid / out_ready| out_char[7:0], last_char, clipped
//
//  Ordinary bytes are taken back to back while the sequencer is idle.
//  A printing newline is taken like any other byte; then each output character
//  needs a store read, then presentation, and each empty field adds a skip step.
//  in_ready is low from the cycle after a printing newline until the LF is taken.
//  out_ready low holds the current character; reset needs no clearing pass.
`default_nettype none

module nmea_gga_position_filter
    import gga_pkg::*;
#(
    parameter int LINE_CAP  = 100,
    parameter int COORD_MAX = 12,
    parameter int HEMI_MAX  = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] out_char,
    output logic            last_char,
    output logic            clipped
);

    localparam int POS_W     = $clog2(LINE_CAP);
    localparam int MEM_DEPTH = 2 * (COORD_MAX + HEMI_MAX);
    localparam int AW        = $clog2(MEM_DEPTH);

    logic          take;
    logic          idle;
    emit_req_t     req;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign in_ready = idle;
    assign take     = in_valid && in_ready;

    gga_parse #(
        .LINE_CAP  (LINE_CAP),
        .COORD_MAX (COORD_MAX),
        .HEMI_MAX  (HEMI_MAX),
        .POS_W     (POS_W),
        .AW        (AW)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .req     (req)
    );

    gga_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gga_emit #(
        .COORD_MAX (COORD_MAX),
        .HEMI_MAX  (HEMI_MAX),
        .AW        (AW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .idle      (idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char),
        .clipped   (clipped)
    );

    // store is never written while the sequencer reads it
    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !idle |-> !wr_en)
        else $error("field store written during output");

    a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> !in_ready)
        else $error("input not held off after printing newline");

    a_lf_releases_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_char) |=> in_ready)
        else $error("input not reopened after final LF");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input open while a character is shown");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the GGA position filter: byte lines in, checked text out.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gga_pkg::*;

    localparam int LINE_CAP    = 100;
    localparam int COORD_MAX   = 12;
    localparam int HEMI_MAX    = 2;
    localparam int RAND_BYTES  = 360;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 400000;

    // Tracks the line state of the filter and the text each newline should print.
    class gga_scoreboard #(int LINE_CAP = 100, int COORD_MAX = 12, int HEMI_MAX = 2);
        typedef struct {
            logic [7:0] ch;
            logic       last;
            logic       clip;
        } text_char_t;

        text_char_t  text_q[$];
        int          errors;
        string       tag_text = "$GNGGA";

        logic [6:0]  line_pos;
        bit          prefix_ok;
        logic [2:0]  token_count;
        bit          in_token;
        logic [7:0]  lat_chars[COORD_MAX];
        logic [7:0]  lon_chars[COORD_MAX];
        logic [7:0]  ns_chars[HEMI_MAX];
        logic [7:0]  ew_chars[HEMI_MAX];
        logic [3:0]  flen[4];
        logic [7:0]  fix_char;
        bit          fix_seen;
        bit          trunc;
        bit          text_done;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_pos    = '0;
            prefix_ok   = 1'b1;
            token_count = '0;
            in_token    = 1'b0;
            foreach (flen[i]) flen[i] = '0;
            fix_char    = '0;
            fix_seen    = 1'b0;
            trunc       = 1'b0;
            text_done   = 1'b0;
        endfunction

        function int pending();
            return text_q.size();
        endfunction

        function void push_char(logic [7:0] c, logic last);
            text_char_t e;
            e.ch   = c;
            e.last = last;
            e.clip = trunc;
            text_q.push_back(e);
        endfunction

        function void push_text(string s);
            for (int i = 0; i < s.len(); i++)
                push_char(s[i], 1'b0);
        endfunction

        function void capture(logic [1:0] slot, logic [7:0] c);
            int cap;
            cap = (slot == SLOT_LAT || slot == SLOT_LON) ? COORD_MAX : HEMI_MAX;
            if (flen[slot] < cap) begin
                case (slot)
                    SLOT_LAT: lat_chars[flen[slot]] = c;
                    SLOT_NS:  ns_chars[flen[slot]]  = c;
                    SLOT_LON: lon_chars[flen[slot]] = c;
                    default:  ew_chars[flen[slot]]  = c;
                endcase
                flen[slot]++;
            end
            else
                trunc = 1'b1;
        endfunction

        function void split_token(logic [7:0] c);
            if (c == CHAR_COMMA) begin
                in_token = 1'b0;
                return;
            end
            if (!in_token) begin
                in_token = 1'b1;
                if (token_count < TOK_FIX)
                    token_count++;
                if (token_count == TOK_FIX && !fix_seen) begin
                    fix_char = c;
                    fix_seen = 1'b1;
                end
            end
            case (token_count)
                TOK_LAT: capture(SLOT_LAT, c);
                TOK_NS:  capture(SLOT_NS, c);
                TOK_LON: capture(SLOT_LON, c);
                TOK_EW:  capture(SLOT_EW, c);
                default: ;
            endcase
        endfunction

        function void print_position();
            push_text("Lat: ");
            for (int i = 0; i < flen[SLOT_LAT]; i++) push_char(lat_chars[i], 1'b0);
            for (int i = 0; i < flen[SLOT_NS]; i++)  push_char(ns_chars[i], 1'b0);
            push_text(" | Lon: ");
            for (int i = 0; i < flen[SLOT_LON]; i++) push_char(lon_chars[i], 1'b0);
            for (int i = 0; i < flen[SLOT_EW]; i++)  push_char(ew_chars[i], 1'b0);
            push_char(CHAR_CR, 1'b0);
            push_char(CHAR_LF, 1'b1);
        endfunction

        // called for every accepted byte
        function void note_byte(logic [7:0] c);
            if (c == CHAR_LF) begin
                if (prefix_ok && line_pos >= 6 && fix_seen &&
                    (fix_char == FIX_GPS || fix_char == FIX_DGPS))
                    print_position();
                clear_line();
                return;
            end
            if (c == CHAR_CR || line_pos >= LINE_CAP - 1)
                return;
            if (!text_done) begin
                if (c == CHAR_NUL)
                    text_done = 1'b1;
                else begin
                    if (line_pos < 6 && c != tag_text[line_pos])
                        prefix_ok = 1'b0;
                    split_token(c);
                end
            end
            if (text_done && line_pos < 6)
                prefix_ok = 1'b0;
            line_pos++;
        endfunction

        function void check_char(logic [7:0] c, logic last, logic clip);
            text_char_t e;
            if (text_q.size() == 0) begin
                $error("out_char: nothing expected, got %h", c);
                errors++;
                return;
            end
            e = text_q.pop_front();
            if (c !== e.ch) begin
                $error("out_char: expected %h, got %h", e.ch, c);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_char: expected %b, got %b", e.last, last);
                errors++;
            end
            if (clip !== e.clip) begin
                $error("clipped: expected %b, got %b", e.clip, clip);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_char;
    logic       last_char;
    logic       clipped;

    gga_scoreboard #(LINE_CAP, COORD_MAX, HEMI_MAX) sb;

    int         byte_count;
    int         cycle_count;
    bit         quiet;
    bit         hold_req;
    logic [7:0] line_q[$];

    nmea_gga_position_filter #(
        .LINE_CAP  (LINE_CAP),
        .COORD_MAX (COORD_MAX),
        .HEMI_MAX  (HEMI_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char),
        .clipped   (clipped)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly zero, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // token content: mostly digits, sometimes any byte that is not a separator
    function automatic logic [7:0] tok_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7)
            return 8'h30 + 8'($urandom_range(0, 9));
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_COMMA || c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    function automatic int coord_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(3, COORD_MAX);
        if (r < 18) return $urandom_range(COORD_MAX + 1, COORD_MAX + 6);
        if (r == 18) return 0;
        return $urandom_range(40, 70);   // can push the line past its capacity
    endfunction

    function automatic int hemi_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15) return 1;
        if (r < 18) return HEMI_MAX;
        return $urandom_range(0, HEMI_MAX + 3);
    endfunction

    function automatic void push_field(int len);
        line_q.push_back(CHAR_COMMA);
        if ($urandom_range(0, 11) == 0)
            line_q.push_back(CHAR_COMMA);   // empty field, tokens shift
        repeat (len) line_q.push_back(tok_char());
    endfunction

    function automatic void build_gga_line();
        string tag;
        int    r;
        tag = "$GNGGA";
        line_q.delete();
        for (int i = 0; i < tag.len(); i++) line_q.push_back(tag[i]);
        if ($urandom_range(0, 11) == 0)
            line_q[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
        push_field($urandom_range(1, 6));
        push_field(coord_len());
        push_field(hemi_len());
        push_field(coord_len());
        push_field(hemi_len());
        line_q.push_back(CHAR_COMMA);
        r = $urandom_range(0, 9);
        if (r < 4)      line_q.push_back(FIX_GPS);
        else if (r < 8) line_q.push_back(FIX_DGPS);
        else if (r < 9) line_q.push_back(tok_char());
        repeat ($urandom_range(0, 3)) push_field($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0)
            line_q.insert($urandom_range(0, line_q.size()), CHAR_CR);
        if ($urandom_range(0, 14) == 0)
            line_q.insert($urandom_range(0, line_q.size()), CHAR_NUL);
        if ($urandom_range(0, 9) < 7)
            line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
    endfunction

    function automatic void build_noise_line();
        line_q.delete();
        repeat ($urandom_range(0, 25)) line_q.push_back(8'($urandom_range(0, 255)));
        line_q.push_back(CHAR_LF);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        byte_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_queued_line();
        for (int i = 0; i < line_q.size(); i++)
            send_byte(line_q[i]);
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, plus one long hold when asked
    initial begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_char(out_char, last_char, clipped);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        int sel;
        sb         = new();
        byte_count = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // good fix with CR; receiver holds off while the next line is offered
        send_text("$GNGGA,9,4807.038,N,01131.000,E,1,08");
        send_byte(CHAR_CR);
        hold_req = 1'b1;
        send_byte(CHAR_LF);
        // empty fields and overlong tokens, DGPS fix
        send_text("$GNGGA,,T,,1234567890123456,NSW,77,EEE,2\n");
        send_text("$GNGGA,1,2,3,4,5,0\n");          // fix code not printable
        send_text("$GNGGA,1,2,3,4,5\n");            // no fix token
        send_text("$GPGGA,1,2,3,4,5,1\n");          // wrong prefix
        send_text("$GNG\n");                        // short line
        send_byte(CHAR_LF);
        // NUL after the fix token: rest of the line is dead text
        send_text("$GNGGA,1,2,3,4,5,1");
        send_byte(CHAR_NUL);
        send_text(",9,");
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        // NUL inside the prefix
        send_text("$GN");
        send_byte(CHAR_NUL);
        send_text("GGA,1,2,3,4,5,1\n");
        // byte extremes inside captured tokens
        send_text("$GNGGA,1,");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_text(",N,");
        send_byte(8'h80);
        send_text(",W,2\n");
        // long line, fix already seen before the cut
        send_text("$GNGGA,1,2,3,4,5,1,");
        repeat (90) send_byte("x");
        send_byte(CHAR_LF);
        // long line, fix lies beyond the cut
        send_text("$GNGGA,");
        repeat (95) send_byte("7");
        send_text(",1,2,3,4,1\n");

        byte_count = 0;
        while (byte_count < RAND_BYTES) begin
            quiet = ($urandom_range(0, 4) == 0);
            sel   = $urandom_range(0, 19);
            if (sel < 3)
                build_noise_line();
            else begin
                build_gga_line();
                if (sel < 5)   // broken: cut somewhere, line runs into the next
                    while (line_q.size() > 1 && $urandom_range(0, 3) != 0)
                        void'(line_q.pop_back());
            end
            if ($urandom_range(0, 9) == 0)
                hold_req = 1'b1;
            send_queued_line();
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
